// ----- design/sms_pkg.sv -----
package sms_pkg;

    // Default capacity of the matrix store, in rows and in columns.
    localparam int MAX_DIM_DEF = 16;

    // Field widths fixed by the item formats.
    localparam int OP_W    = 2;
    localparam int POS_W   = 4;
    localparam int VALUE_W = 32;
    localparam int SUM_W   = 40;
    localparam int SIZE_W  = 5;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

    // Item opcodes.
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_DIAG   = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]           opcode;
        logic [POS_W-1:0]          row;
        logic [POS_W-1:0]          col;
        logic signed [VALUE_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic                    found;
        logic [POS_W-1:0]        hit_row;
        logic [POS_W-1:0]        hit_col;
        logic signed [SUM_W-1:0] diag_sum;
    } out_item_t;

endpackage

// ----- design/sms_in_if.sv -----
interface sms_in_if;
    logic              valid;
    logic              ready;
    sms_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- design/sms_out_if.sv -----
interface sms_out_if;
    logic               valid;
    logic               ready;
    sms_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- design/sms_core.sv -----
module sms_core #(
    parameter int MAX_DIM = sms_pkg::MAX_DIM_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [sms_pkg::SIZE_W-1:0]  size,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  sms_pkg::in_item_t           item,
    output logic                        res_valid,
    input  logic                        res_ready,
    output sms_pkg::out_item_t          res
);

    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = 1 << ADDR_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SRCH = 2'd1;
    localparam logic [1:0] ST_DIAG = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [sms_pkg::VALUE_W-1:0] mem [0:DEPTH-1];
    logic [sms_pkg::VALUE_W-1:0] rd_data_reg;

    logic [1:0]                        state_reg, state_next;
    logic [IDX_W-1:0]                  row_reg, row_next;
    logic [IDX_W-1:0]                  col_reg, col_next;
    logic                              second_reg, second_next;
    logic signed [sms_pkg::VALUE_W-1:0] target_reg, target_next;
    logic signed [sms_pkg::SUM_W-1:0]  sum_reg, sum_next;
    sms_pkg::out_item_t                res_reg, res_next;

    logic [IDX_W-1:0]  n_m1;
    logic [IDX_W-1:0]  anti_col;
    logic [31:0]       wr_row32, wr_col32, cur_row32, cur_col32;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic signed [sms_pkg::VALUE_W-1:0] entry;
    logic              accept;

    // Last index in use, with the size clamped into one to MAX_DIM.
    always_comb
    begin
        if (size == '0)
        begin
            n_m1 = '0;
        end
        else if (32'(size) > MAX_DIM)
        begin
            n_m1 = IDX_W'(MAX_DIM - 1);
        end
        else
        begin
            n_m1 = IDX_W'(size - 5'd1);
        end
    end

    assign accept     = item_valid && item_ready;
    assign item_ready = (state_reg == ST_IDLE);
    assign res_valid  = (state_reg == ST_DONE);
    assign res        = res_reg;

    assign wr_row32 = 32'(item.row);
    assign wr_col32 = 32'(item.col);
    assign wr_en    = accept && (item.opcode == sms_pkg::OP_WRITE)
                      && (wr_row32 < MAX_DIM) && (wr_col32 < MAX_DIM);
    assign wr_addr  = {wr_row32[IDX_W-1:0], wr_col32[IDX_W-1:0]};

    assign cur_row32 = 32'(row_reg);
    assign cur_col32 = 32'(col_reg);
    assign anti_col  = n_m1 - row_reg;
    assign entry     = signed'(rd_data_reg);

    // The memory is always read at the position the walk moves to next.
    assign rd_addr = {row_next, col_next};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= item.value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next  = state_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        second_next = second_reg;
        target_next = target_reg;
        sum_next    = sum_reg;
        res_next    = res_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    target_next = item.value;
                    sum_next    = '0;
                    second_next = 1'b0;
                    row_next    = '0;
                    if (item.opcode == sms_pkg::OP_SEARCH)
                    begin
                        col_next   = n_m1;
                        state_next = ST_SRCH;
                    end
                    else if (item.opcode == sms_pkg::OP_DIAG)
                    begin
                        col_next   = '0;
                        state_next = ST_DIAG;
                    end
                end
            end

            ST_SRCH:
            begin
                if (entry == target_reg)
                begin
                    res_next.found    = 1'b1;
                    res_next.hit_row  = cur_row32[sms_pkg::POS_W-1:0];
                    res_next.hit_col  = cur_col32[sms_pkg::POS_W-1:0];
                    res_next.diag_sum = '0;
                    state_next        = ST_DONE;
                end
                else if (target_reg < entry)
                begin
                    if (col_reg == '0)
                    begin
                        res_next   = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        col_next = col_reg - 1'b1;
                    end
                end
                else
                begin
                    if (row_reg == n_m1)
                    begin
                        res_next   = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
            end

            ST_DIAG:
            begin
                sum_next = sum_reg + sms_pkg::SUM_W'(entry);
                if (!second_reg && (anti_col != row_reg))
                begin
                    col_next    = anti_col;
                    second_next = 1'b1;
                end
                else if (row_reg == n_m1)
                begin
                    res_next          = '0;
                    res_next.diag_sum = sum_next;
                    state_next        = ST_DONE;
                end
                else
                begin
                    row_next    = row_reg + 1'b1;
                    col_next    = row_reg + 1'b1;
                    second_next = 1'b0;
                end
            end

            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg    <= row_next;
        col_reg    <= col_next;
        second_reg <= second_next;
        target_reg <= target_next;
        sum_reg    <= sum_next;
        res_reg    <= res_next;
    end

endmodule

// ----- design/sorted_matrix_staircase_search.sv -----
// Channel   Role    Payload                                  Moves when
// cmd       sink    opcode, row, col, value                  valid && ready
// rsp       source  found, hit_row, hit_col, diag_sum        valid && ready
// cfg       write   size_in_use (5 bits)                     cfg_we high
//
// One command is worked at a time, and the walk issues one read per cycle.
// A write is stored when it is accepted. A search is accepted, walks the
// staircase from the top-right corner and then hands over its result. A
// diagonal sum reads both diagonals, the center of an odd n only once.
// Reset clears the control state and sets size_in_use to 16; the matrix store
// is not cleared. A stalled rsp holds one result in the output register while
// the next command is already being worked.
module sorted_matrix_staircase_search #(
    parameter int MAX_DIM = sms_pkg::MAX_DIM_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    sms_in_if.sink                     cmd,
    sms_out_if.source                  rsp,
    input  logic                       cfg_we,
    input  logic [sms_pkg::SIZE_W-1:0] cfg_data
);

    // Configuration register: the number of rows and columns in use.
    logic [sms_pkg::SIZE_W-1:0] size_reg;

    // Output register that decouples the result from the walk engine.
    logic               out_valid_reg;
    sms_pkg::out_item_t out_data_reg;

    logic               res_valid;
    logic               res_ready;
    sms_pkg::out_item_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= sms_pkg::SIZE_RESET;
        end
        else if (cfg_we)
        begin
            size_reg <= cfg_data;
        end
    end

    // The engine may hand over a result whenever the output register is
    // empty or is being emptied by a transfer in this cycle.
    assign res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // The engine holds the matrix store and steps the staircase walk or the
    // diagonal sum one memory read per cycle.
    sms_core #(
        .MAX_DIM (MAX_DIM)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .size       (size_reg),
        .item_valid (cmd.valid),
        .item_ready (cmd.ready),
        .item       (cmd.data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

endmodule

// ----- dv/sms_staircase_checker.sv -----
`timescale 1ns / 1ps

module sms_staircase_checker #(
    parameter int DIM = sms_pkg::MAX_DIM_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    sms_in_if                          cmd,
    sms_out_if                         rsp,
    input  logic                       cfg_we,
    input  logic [sms_pkg::SIZE_W-1:0] cfg_data,
    output int                         fail_count,
    output int                         pending
);

    // Private copy of the matrix store and of the size register.
    logic signed [sms_pkg::VALUE_W-1:0] grid [DIM][DIM];
    logic [sms_pkg::SIZE_W-1:0]         size_reg;
    sms_pkg::out_item_t                 answers_due[$];
    sms_pkg::out_item_t                 want;
    int                                 errs = 0;

    function automatic int dim_in_use();
        int n;
        n = size_reg;
        if (n == 0) n = 1;
        if (n > DIM) n = DIM;
        return n;
    endfunction

    // Staircase walk from the top-right corner of the part in use.
    function automatic sms_pkg::out_item_t walk_staircase(
        logic signed [sms_pkg::VALUE_W-1:0] target
    );
        int                 n;
        int                 r;
        int                 c;
        int                 last_col;
        bit                 hit;
        sms_pkg::out_item_t res;
        n   = dim_in_use();
        r   = 0;
        c   = n;
        hit = 1'b0;
        res = '0;
        while (!hit && r < n && c > 0)
        begin
            if (grid[r][c-1] == target) hit = 1'b1;
            else if (target < grid[r][c-1]) c--;
            else r++;
        end
        if (hit)
        begin
            last_col    = c - 1;
            res.found   = 1'b1;
            res.hit_row = r[sms_pkg::POS_W-1:0];
            res.hit_col = last_col[sms_pkg::POS_W-1:0];
        end
        return res;
    endfunction

    // Both diagonals; the center of an odd size is added only once.
    function automatic sms_pkg::out_item_t sum_diagonals();
        int                               n;
        logic signed [sms_pkg::SUM_W-1:0] acc;
        logic signed [sms_pkg::SUM_W-1:0] term;
        sms_pkg::out_item_t               res;
        n   = dim_in_use();
        acc = '0;
        res = '0;
        for (int i = 0; i < n; i++)
        begin
            term = grid[i][i];
            acc += term;
            if (i != n - 1 - i)
            begin
                term = grid[i][n-1-i];
                acc += term;
            end
        end
        res.diag_sum = acc;
        return res;
    endfunction

    task automatic report(string what, sms_pkg::out_item_t got, sms_pkg::out_item_t exp_item);
        $display("[%0t] %s: got %0b/%0d/%0d/%0d, wanted %0b/%0d/%0d/%0d",
                 $time, what, got.found, got.hit_row, got.hit_col, got.diag_sum,
                 exp_item.found, exp_item.hit_row, exp_item.hit_col, exp_item.diag_sum);
        errs++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            answers_due.delete();
            size_reg = sms_pkg::SIZE_RESET;
            pending    <= 0;
            fail_count <= errs;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (answers_due.size() == 0)
                begin
                    report("result with nothing outstanding", rsp.data, '0);
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (rsp.data.found !== want.found || rsp.data.hit_row !== want.hit_row ||
                        rsp.data.hit_col !== want.hit_col || rsp.data.diag_sum !== want.diag_sum)
                        report("result mismatch", rsp.data, want);
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                case (cmd.data.opcode)
                    sms_pkg::OP_WRITE:  grid[cmd.data.row][cmd.data.col] = cmd.data.value;
                    sms_pkg::OP_SEARCH: answers_due.push_back(walk_staircase(cmd.data.value));
                    sms_pkg::OP_DIAG:   answers_due.push_back(sum_diagonals());
                    default:            ;
                endcase
            end
            if (cfg_we) size_reg = cfg_data;
            pending    <= answers_due.size();
            fail_count <= errs;
        end
    end

endmodule

// ----- dv/sorted_matrix_staircase_search_tb.sv -----
`timescale 1ns / 1ps

module sorted_matrix_staircase_search_tb;

    localparam int     DIM           = sms_pkg::MAX_DIM_DEF;
    // A search walks at most 2*DIM-1 entries and a diagonal sum at most 2*DIM, so
    // this settle wait covers any command still in flight.
    localparam int     SETTLE_CYCLES = 2 * DIM + 8;
    localparam int     IDLE_LIMIT    = 2000;
    localparam int     ITEM_TARGET   = 900;
    localparam longint VAL_MIN       = -64'sd2147483648;
    localparam longint VAL_MAX       = 64'sd2147483647;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_we;
    logic [sms_pkg::SIZE_W-1:0] cfg_data;
    int                         fail_count;
    int                         pending;

    sms_in_if  cmd_if ();
    sms_out_if rsp_if ();

    // Stimulus-side picture of the store, used only to pick sorted values and
    // targets that actually occur in the matrix.
    longint shadow [DIM][DIM];
    bit     all_written;
    int     item_count;
    int     burst_left;
    int     ready_left;

    always #5 clk = ~clk;

    sorted_matrix_staircase_search #(
        .MAX_DIM (DIM)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd_if),
        .rsp      (rsp_if),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    sms_staircase_checker #(
        .DIM (DIM)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_if),
        .rsp        (rsp_if),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // The receiver alternates between long stretches of accepting every
    // result and short stalls, so stalls land on every phase of the walk.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            ready_left = 0;
        end
        else if (ready_left > 0)
        begin
            ready_left--;
        end
        else if (rsp_if.ready)
        begin
            rsp_if.ready <= 1'b0;
            ready_left = $urandom_range(0, 7);
        end
        else
        begin
            rsp_if.ready <= 1'b1;
            ready_left = $urandom_range(0, 40);
        end
    end

    // The run is ended if neither channel moves a transfer for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Sends one command. The sender works in bursts: when a burst is used up
    // it may drop valid for a random gap before starting the next one. The task
    // returns at the edge where the transfer took place.
    task automatic send_cmd(logic [sms_pkg::OP_W-1:0] op, logic [sms_pkg::POS_W-1:0] r,
                            logic [sms_pkg::POS_W-1:0] c,
                            logic signed [sms_pkg::VALUE_W-1:0] v);
        sms_pkg::in_item_t it;
        int                gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 10);
            if (gap > 0)
            begin
                cmd_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        it.opcode = op;
        it.row    = r;
        it.col    = c;
        it.value  = v;
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= it;
        do @(posedge clk); while (!cmd_if.ready);
        burst_left--;
        if (op != sms_pkg::OP_NONE) item_count++;
    endtask

    task automatic write_entry(int r, int c, longint v);
        send_cmd(sms_pkg::OP_WRITE, r[sms_pkg::POS_W-1:0], c[sms_pkg::POS_W-1:0],
                 v[sms_pkg::VALUE_W-1:0]);
        shadow[r][c] = v;
    endtask

    // The row and column fields are unused by a search, so they carry noise.
    task automatic search_for(longint t);
        send_cmd(sms_pkg::OP_SEARCH, sms_pkg::POS_W'($urandom), sms_pkg::POS_W'($urandom),
                 t[sms_pkg::VALUE_W-1:0]);
    endtask

    task automatic ask_diag_sum();
        send_cmd(sms_pkg::OP_DIAG, sms_pkg::POS_W'($urandom), sms_pkg::POS_W'($urandom),
                 sms_pkg::VALUE_W'($urandom));
    endtask

    // Drops valid and waits until every expected result has come back, then
    // lets a trailing write or ignored command finish inside the block.
    task automatic wait_idle();
        cmd_if.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_size(int v);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= sms_pkg::SIZE_W'(v);
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Smallest value that keeps row and column order given the entries above
    // and to the left.
    function automatic longint floor_of(int r, int c);
        longint lo;
        lo = VAL_MIN;
        if (r > 0 && shadow[r-1][c] > lo) lo = shadow[r-1][c];
        if (c > 0 && shadow[r][c-1] > lo) lo = shadow[r][c-1];
        return lo;
    endfunction

    initial
    begin : stimulus
        int     phase;
        int     n;
        int     size_code;
        int     count;
        int     pick;
        int     r;
        int     c;
        int     step;
        longint base;
        longint v;
        longint hi;
        longint t;

        cmd_if.valid = 1'b0;
        cmd_if.data  = '0;
        cfg_we       = 1'b0;
        cfg_data     = '0;
        rst_n        = 1'b0;
        burst_left   = 0;
        item_count   = 0;
        all_written  = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. A one by one matrix holding the most negative value:
        // a hit, a miss that leaves through the bottom, and its diagonal sum.
        set_size(1);
        write_entry(0, 0, VAL_MIN);
        search_for(VAL_MIN);
        search_for(VAL_MAX);
        ask_diag_sum();
        // The unused opcode must give no result at all.
        send_cmd(sms_pkg::OP_NONE, '1, '1, '1);

        // Two by two: hits in the lower row, two misses that fall off the left edge,
        // and an even-sized diagonal sum.
        set_size(2);
        write_entry(0, 0, -5);
        write_entry(0, 1, 0);
        write_entry(1, 0, 3);
        write_entry(1, 1, VAL_MAX);
        search_for(3);
        search_for(VAL_MAX);
        search_for(1);
        search_for(VAL_MIN);
        ask_diag_sum();
        // A write outside the part in use is still kept by the store.
        write_entry(15, 15, 64'h5A5AA5A5);

        // Three by three with a repeated value; the odd size counts the center
        // entry only once in the diagonal sum.
        set_size(3);
        write_entry(0, 0, VAL_MIN);
        write_entry(0, 1, -7);
        write_entry(0, 2, 0);
        write_entry(1, 0, -7);
        write_entry(1, 1, 1);
        write_entry(1, 2, 9);
        write_entry(2, 0, 4);
        write_entry(2, 1, 9);
        write_entry(2, 2, VAL_MAX);
        search_for(9);
        ask_diag_sum();

        // Random part, in phases. Each phase sets the size while the block is
        // idle, loads a fresh sorted matrix into the part in use (the full store
        // only once), and then mixes searches, diagonal sums, writes and unused opcodes.
        phase = 0;
        while (item_count < ITEM_TARGET)
        begin
            case (phase)
                0: size_code = DIM;
                1: size_code = 0;
                2: size_code = (1 << sms_pkg::SIZE_W) - 1;
                3: size_code = 1;
                4: size_code = 5;
                default:
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 7) size_code = $urandom_range(1, 6);
                    else if (pick == 7) size_code = $urandom_range(7, DIM - 1);
                    else if (pick == 8) size_code = DIM;
                    else if ($urandom_range(0, 1) != 0) size_code = 0;
                    else size_code = $urandom_range(DIM + 1, (1 << sms_pkg::SIZE_W) - 1);
                end
            endcase
            set_size(size_code);
            n = (size_code == 0) ? 1 : ((size_code > DIM) ? DIM : size_code);

            // The full store is loaded only once, since it is costly; later
            // full-size phases work on whatever it holds by then.
            if (n < DIM || !all_written)
            begin
                case ($urandom_range(0, 3))
                    0:       base = VAL_MIN;
                    1:       base = longint'(int'($urandom));
                    2:       base = longint'($urandom_range(0, 20)) - 10;
                    default: base = VAL_MAX - $urandom_range(0, 1000);
                endcase
                case ($urandom_range(0, 3))
                    0:       step = 0;
                    1:       step = 3;
                    2:       step = 1000;
                    default: step = 1 << 27;
                endcase
                for (int i = 0; i < n; i++)
                begin
                    for (int j = 0; j < n; j++)
                    begin
                        v = (i == 0 && j == 0) ? base : floor_of(i, j);
                        v += $urandom_range(0, step);
                        if (v > VAL_MAX) v = VAL_MAX;
                        write_entry(i, j, v);
                    end
                end
                if (n == DIM) all_written = 1'b1;
            end

            count = $urandom_range(10, 40);
            repeat (count)
            begin
                pick = $urandom_range(0, 99);
                r    = $urandom_range(0, n - 1);
                c    = $urandom_range(0, n - 1);
                if (pick < 45)
                begin
                    // A value that is in the matrix, so the walk should hit.
                    search_for(shadow[r][c]);
                end
                else if (pick < 60)
                begin
                    // Just beside an entry: mostly misses deep in the walk.
                    t = shadow[r][c] + (($urandom_range(0, 1) != 0) ? 1 : -1);
                    if (t > VAL_MAX) t = VAL_MAX;
                    if (t < VAL_MIN) t = VAL_MIN;
                    search_for(t);
                end
                else if (pick < 68)
                begin
                    search_for(longint'(int'($urandom)));
                end
                else if (pick < 72)
                begin
                    search_for(($urandom_range(0, 1) != 0) ? VAL_MAX : VAL_MIN);
                end
                else if (pick < 84)
                begin
                    ask_diag_sum();
                end
                else if (pick < 92)
                begin
                    // A rewrite that keeps the part in use sorted.
                    hi = VAL_MAX;
                    if (r < n - 1 && shadow[r+1][c] < hi) hi = shadow[r+1][c];
                    if (c < n - 1 && shadow[r][c+1] < hi) hi = shadow[r][c+1];
                    v = floor_of(r, c);
                    if (hi < v) hi = v;
                    v += longint'($urandom_range(0, 32'(hi - v)));
                    write_entry(r, c, v);
                end
                else if (pick < 96)
                begin
                    // Noise: any entry of the store, any value, sorted or not.
                    write_entry($urandom_range(0, DIM - 1), $urandom_range(0, DIM - 1),
                                longint'(int'($urandom)));
                end
                else
                begin
                    send_cmd(sms_pkg::OP_NONE, sms_pkg::POS_W'($urandom),
                             sms_pkg::POS_W'($urandom), sms_pkg::VALUE_W'($urandom));
                end
            end
            phase++;
        end

        wait_idle();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
